FILE: hw/rtl/led_strip_animation_generator_assert.svh
// Assertion helpers used by the top-level RTL.
`ifndef LED_STRIP_ANIMATION_GENERATOR_ASSERT_SVH
`define LED_STRIP_ANIMATION_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSAG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsag assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsag assertion failed");

`endif

FILE: hw/rtl/lsag_pkg.sv
package lsag_pkg;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_SOLID = 3'd1,
        MODE_SNAKE = 3'd2,
        MODE_PULSE = 3'd3,
        MODE_XMAS  = 3'd4,
        MODE_XMAS2 = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_LENGTH = 3'd1,
        REG_POWER  = 3'd2,
        REG_RED    = 3'd3,
        REG_GREEN  = 3'd4,
        REG_BLUE   = 3'd5
    } t_reg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;   // latch frame parameters, clear pixel counter
        logic load;    // load next pixel into the output register
        logic finish;  // advance the frame phase
    } t_cmd;

    typedef struct packed {
        logic last;      // pixel counter sits on the final pixel
        logic out_free;  // output register can take a pixel this cycle
    } t_status;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [8:0]  FULL_POWER    = 9'd256;
    localparam logic [6:0]  PULSE_STEPS   = 7'd50;
    localparam logic [6:0]  PULSE_PERIOD  = 7'd101;
    localparam logic [6:0]  XMAS_PERIOD   = 7'd3;
    localparam logic [6:0]  XMAS2_PERIOD  = 7'd5;
    // floor(q / 50) == (q * DIV50_MUL) >> DIV50_SHIFT for q below 12800
    localparam logic [14:0] DIV50_MUL     = 15'd20972;
    localparam int          DIV50_SHIFT   = 20;

    localparam logic [6:0]  RESET_LENGTH  = 7'd8;
    localparam logic [7:0]  RESET_RED     = 8'd255;
    localparam logic [7:0]  RESET_GREEN   = 8'd0;
    localparam logic [7:0]  RESET_BLUE    = 8'd0;

endpackage

FILE: hw/rtl/lsag_in_if.sv
interface lsag_in_if;
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink (input valid, input frame_tick, output ready);
endinterface

FILE: hw/rtl/lsag_out_if.sv
interface lsag_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] pixel_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;

    modport source (output valid, output pixel_index, output red_out, output green_out,
                    output blue_out, output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input red_out, input green_out,
                  input blue_out, input last_pixel, output ready);
endinterface

FILE: hw/rtl/lsag_ctrl.sv
module lsag_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_tick,
    output logic             o_in_ready,
    input  lsag_pkg::t_status i_status,
    output lsag_pkg::t_cmd   o_cmd
);

    lsag_pkg::t_state r_state;
    lsag_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsag_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsag_pkg::S_IDLE: begin
                // a transfer with a clear tick yields no frame
                if (i_in_valid && i_in_tick) begin
                    n_state = lsag_pkg::S_MUL;
                end
            end
            lsag_pkg::S_MUL:   n_state = lsag_pkg::S_SCALE;
            lsag_pkg::S_SCALE: n_state = lsag_pkg::S_DIV;
            lsag_pkg::S_DIV:   n_state = lsag_pkg::S_EMIT;
            lsag_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.last) begin
                    n_state = lsag_pkg::S_IDLE;
                end
            end
            default: n_state = lsag_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            lsag_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid && i_in_tick;
            end
            lsag_pkg::S_EMIT: begin
                o_cmd.load   = i_status.out_free;
                o_cmd.finish = i_status.out_free && i_status.last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lsag_datapath.sv
module lsag_datapath #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsag_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lsag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  lsag_pkg::t_cmd                      i_cmd,
    output lsag_pkg::t_status                   o_status,
    lsag_out_if.source                          o_out
);

    localparam logic [6:0] MaxLen = 7'(MAX_PIXELS);

    // configuration
    logic [2:0] r_mode;
    logic [6:0] r_strip_length;
    logic [8:0] r_power_level;
    logic [7:0] r_base [3];
    logic [6:0] r_phase;

    // frame parameters latched at frame start
    logic [6:0] r_ph;
    logic [6:0] r_len;
    logic [6:0] r_period;
    logic [8:0] r_pw;
    logic [5:0] r_step;

    // setup pipeline, one lane per colour
    logic [16:0] r_prod1 [3];
    logic [22:0] r_prod2 [3];
    logic [29:0] r_quot  [3];
    logic [7:0]  r_chr;

    // pixel walk
    logic [5:0] r_pix;
    logic [2:0] r_res;

    // output register
    logic       r_out_valid;
    logic [5:0] r_out_index;
    logic [7:0] r_out_red;
    logic [7:0] r_out_green;
    logic [7:0] r_out_blue;
    logic       r_out_last;

    logic [6:0]  len_eff;
    logic [6:0]  period;
    logic [6:0]  ph_eff;
    logic [8:0]  pw_sat;
    logic [6:0]  step_wide;
    logic [16:0] chr_full;
    logic [6:0]  n_phase;
    logic [2:0]  n_res;
    logic        last;
    logic [7:0]  pix_red;
    logic [7:0]  pix_green;
    logic [7:0]  pix_blue;

    always_comb begin
        if (r_strip_length == 7'd0) begin
            len_eff = 7'd1;
        end else if (r_strip_length > MaxLen) begin
            len_eff = MaxLen;
        end else begin
            len_eff = r_strip_length;
        end

        case (r_mode)
            lsag_pkg::MODE_SNAKE: period = len_eff;
            lsag_pkg::MODE_PULSE: period = lsag_pkg::PULSE_PERIOD;
            lsag_pkg::MODE_XMAS:  period = lsag_pkg::XMAS_PERIOD;
            lsag_pkg::MODE_XMAS2: period = lsag_pkg::XMAS2_PERIOD;
            default:              period = 7'd1;
        endcase

        ph_eff    = (r_phase >= period) ? 7'd0 : r_phase;
        pw_sat    = (r_power_level > lsag_pkg::FULL_POWER) ? lsag_pkg::FULL_POWER
                                                           : r_power_level;
        step_wide = (ph_eff < lsag_pkg::PULSE_STEPS) ? ph_eff
                                                     : (7'd100 - ph_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= lsag_pkg::MODE_OFF;
            r_strip_length <= lsag_pkg::RESET_LENGTH;
            r_power_level  <= lsag_pkg::FULL_POWER;
            r_base[0]      <= lsag_pkg::RESET_RED;
            r_base[1]      <= lsag_pkg::RESET_GREEN;
            r_base[2]      <= lsag_pkg::RESET_BLUE;
            r_phase        <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsag_pkg::REG_MODE: begin
                        r_mode  <= i_cfg_data[2:0];
                        r_phase <= 7'd0;
                    end
                    lsag_pkg::REG_LENGTH: r_strip_length <= i_cfg_data[6:0];
                    lsag_pkg::REG_POWER:  r_power_level  <= i_cfg_data;
                    lsag_pkg::REG_RED:    r_base[0]      <= i_cfg_data[7:0];
                    lsag_pkg::REG_GREEN:  r_base[1]      <= i_cfg_data[7:0];
                    lsag_pkg::REG_BLUE:   r_base[2]      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_phase <= n_phase;
            end
        end
    end

    always_comb begin
        n_phase = r_ph + 7'd1;
        if (n_phase >= r_period) begin
            n_phase = 7'd0;
        end
    end

    // latch frame parameters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ph     <= ph_eff;
            r_len    <= len_eff;
            r_period <= period;
            r_pw     <= pw_sat;
            r_step   <= step_wide[5:0];
        end
    end

    // setup pipeline runs freely; controller waits for its latency
    assign chr_full = {r_pw, 8'd0} - {8'd0, r_pw};

    always_ff @(posedge i_clk) begin
        r_chr <= chr_full[15:8];
        for (int c = 0; c < 3; c++) begin
            r_prod1[c] <= {9'd0, r_base[c]} * {8'd0, r_pw};
            r_prod2[c] <= {6'd0, r_prod1[c]} * {17'd0, r_step};
            r_quot[c]  <= {15'd0, r_prod2[c][22:8]} * {15'd0, lsag_pkg::DIV50_MUL};
        end
    end

    assign last = ({1'b0, r_pix} + 7'd1) == r_len;

    always_comb begin
        n_res = r_res + 3'd1;
        case (r_mode)
            lsag_pkg::MODE_XMAS:  if (r_res == 3'd2) n_res = 3'd0;
            lsag_pkg::MODE_XMAS2: if (r_res == 3'd4) n_res = 3'd0;
            default:              n_res = 3'd0;
        endcase
    end

    always_comb begin
        pix_red   = 8'd0;
        pix_green = 8'd0;
        pix_blue  = 8'd0;
        case (r_mode)
            lsag_pkg::MODE_SOLID: pix_red = 8'hFF;
            lsag_pkg::MODE_SNAKE: begin
                if ({1'b0, r_pix} == r_ph) begin
                    pix_red   = r_prod1[0][15:8];
                    pix_green = r_prod1[1][15:8];
                    pix_blue  = r_prod1[2][15:8];
                end
            end
            lsag_pkg::MODE_PULSE: begin
                pix_red   = r_quot[0][lsag_pkg::DIV50_SHIFT +: 8];
                pix_green = r_quot[1][lsag_pkg::DIV50_SHIFT +: 8];
                pix_blue  = r_quot[2][lsag_pkg::DIV50_SHIFT +: 8];
            end
            lsag_pkg::MODE_XMAS: begin
                if (r_res == 3'd0) begin
                    pix_red = r_chr;
                end else if (r_res == 3'd1) begin
                    pix_green = r_chr;
                end else begin
                    pix_blue = r_chr;
                end
            end
            lsag_pkg::MODE_XMAS2: begin
                if (r_res == 3'd0) begin
                    pix_red = r_chr;
                end else begin
                    pix_green = r_chr;
                end
            end
            default: pix_red = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pix <= 6'd0;
            r_res <= ph_eff[2:0];
        end else if (i_cmd.load) begin
            r_pix <= r_pix + 6'd1;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_index <= r_pix;
            r_out_red   <= pix_red;
            r_out_green <= pix_green;
            r_out_blue  <= pix_blue;
            r_out_last  <= last;
        end
    end

    assign o_status.last     = last;
    assign o_status.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_index = r_out_index;
    assign o_out.red_out     = r_out_red;
    assign o_out.green_out   = r_out_green;
    assign o_out.blue_out    = r_out_blue;
    assign o_out.last_pixel  = r_out_last;

endmodule

FILE: hw/rtl/led_strip_animation_generator.sv
// Frame generator for an addressable LED strip. Each input transfer with
// frame_tick set produces one frame of strip_length pixels (clamped to
// 1..MAX_PIXELS), indexed from 0, the final one flagged with last_pixel;
// a transfer with frame_tick clear produces nothing. A frame occupies the
// block through the accept, the setup states MUL, SCALE and DIV for the
// per-frame colour multiplies, then one pixel per cycle through the
// output register while the sink keeps ready high. The next tick is taken
// the cycle after the last pixel enters the output register. Write the
// configuration registers only between frames; writing mode restarts the
// animation phase.
module led_strip_animation_generator #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsag_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lsag_in_if.sink                          i_in,
    lsag_out_if.source                       o_out
);

    `include "led_strip_animation_generator_assert.svh"

    lsag_pkg::t_cmd    cmd;
    lsag_pkg::t_status status;
    logic              in_ready;

    lsag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_tick  (i_in.frame_tick),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lsag_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

    assign i_in.ready = in_ready;

    // a frame in progress blocks the input
    `LSAG_ASSERT_NEXT(a_busy_after_tick, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.frame_tick, !i_in.ready)
    // pixels within a frame follow back to back with rising index
    `LSAG_ASSERT_NEXT(a_pixel_follows, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last_pixel, o_out.valid && (o_out.pixel_index == $past(o_out.pixel_index) + 6'd1))
    // the phase advance only comes with the load of the final pixel
    `LSAG_ASSERT_NOW(a_finish_with_load, i_clk, i_rst_n, cmd.finish, cmd.load && status.last)

endmodule

FILE: tb/sv/led_strip_animation_generator_tb.sv
`timescale 1ns / 1ps

module led_strip_animation_generator_tb;

    localparam int STRIP_MAX      = 64;
    localparam int Q8_FULL        = 256;
    localparam int RAMP_STEPS     = 50;
    localparam int RAMP_PERIOD    = 2 * RAMP_STEPS + 1;
    localparam int TRIO_PERIOD    = 3;
    localparam int FIVE_PERIOD    = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [lsag_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [lsag_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    lsag_in_if  in_ch();
    lsag_out_if out_ch();

    led_strip_animation_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Shadow of the animation registers and phase.
    logic [2:0] cfg_mode   = 3'd0;
    logic [6:0] cfg_length = 7'd8;
    logic [8:0] cfg_power  = 9'd256;
    logic [7:0] cfg_red    = 8'd255;
    logic [7:0] cfg_green  = 8'd0;
    logic [7:0] cfg_blue   = 8'd0;
    logic [6:0] frame_phase = 7'd0;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;

    logic [8:0] power_steps[4] = '{9'd511, 9'd257, 9'd0, 9'd128};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void predict_frame();
        int     len, period, ph, pw, step, r, g, b;
        t_pixel px;
        len = int'(cfg_length);
        if (len < 1) len = 1;
        if (len > STRIP_MAX) len = STRIP_MAX;
        case (cfg_mode)
            lsag_pkg::MODE_SNAKE: period = len;
            lsag_pkg::MODE_PULSE: period = RAMP_PERIOD;
            lsag_pkg::MODE_XMAS:  period = TRIO_PERIOD;
            lsag_pkg::MODE_XMAS2: period = FIVE_PERIOD;
            default:              period = 1;
        endcase
        ph = int'(frame_phase);
        // a phase left over from a longer period restarts the pattern
        if (ph >= period) ph = 0;
        pw = (int'(cfg_power) > Q8_FULL) ? Q8_FULL : int'(cfg_power);
        step = (ph < RAMP_STEPS) ? ph : (2 * RAMP_STEPS - ph);
        for (int i = 0; i < len; i++) begin
            r = 0;
            g = 0;
            b = 0;
            case (cfg_mode)
                lsag_pkg::MODE_SOLID: r = (255 * Q8_FULL) >> 8;
                lsag_pkg::MODE_SNAKE: begin
                    if (i == ph) begin
                        r = (int'(cfg_red) * pw) >> 8;
                        g = (int'(cfg_green) * pw) >> 8;
                        b = (int'(cfg_blue) * pw) >> 8;
                    end
                end
                lsag_pkg::MODE_PULSE: begin
                    r = (int'(cfg_red) * pw * step) / (256 * RAMP_STEPS);
                    g = (int'(cfg_green) * pw * step) / (256 * RAMP_STEPS);
                    b = (int'(cfg_blue) * pw * step) / (256 * RAMP_STEPS);
                end
                lsag_pkg::MODE_XMAS: begin
                    case ((i + ph) % 3)
                        0:       r = (255 * pw) >> 8;
                        1:       g = (255 * pw) >> 8;
                        default: b = (255 * pw) >> 8;
                    endcase
                end
                lsag_pkg::MODE_XMAS2: begin
                    if ((i + ph) % 5 == 0) r = (255 * pw) >> 8;
                    else g = (255 * pw) >> 8;
                end
                default: ;
            endcase
            px.index = 6'(i);
            px.red   = 8'(r);
            px.green = 8'(g);
            px.blue  = 8'(b);
            px.last  = (i + 1 == len);
            expected_pixels.push_back(px);
        end
        ph = ph + 1;
        if (ph >= period) ph = 0;
        frame_phase = 7'(ph);
    endfunction

    task automatic write_reg(lsag_pkg::t_reg_index idx, logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lsag_pkg::REG_MODE: begin
                cfg_mode = value[2:0];
                frame_phase = 7'd0;
            end
            lsag_pkg::REG_LENGTH: cfg_length = value[6:0];
            lsag_pkg::REG_POWER:  cfg_power  = value;
            lsag_pkg::REG_RED:    cfg_red    = value[7:0];
            lsag_pkg::REG_GREEN:  cfg_green  = value[7:0];
            lsag_pkg::REG_BLUE:   cfg_blue   = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One input transfer; optional idle cycles before it.
    task automatic send_tick(bit tick);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid      <= 1'b0;
            in_ch.frame_tick <= 1'($urandom);
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.frame_tick <= tick;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (tick) predict_frame();
    endtask

    // Hold the sender until the strip has drained, then let the block settle.
    task automatic wait_strip_idle();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.index = out_ch.pixel_index;
            got.red   = out_ch.red_out;
            got.green = out_ch.green_out;
            got.blue  = out_ch.blue_out;
            got.last  = out_ch.last_pixel;
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected pixel idx=%0d rgb=%02x/%02x/%02x last=%0b",
                             got.index, got.red, got.green, got.blue, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got.index !== want.index || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("pixel mismatch: expected idx=%0d rgb=%02x/%02x/%02x last=%0b, %s",
                                 want.index, want.red, want.green, want.blue, want.last,
                                 $sformatf("got idx=%0d rgb=%02x/%02x/%02x last=%0b",
                                           got.index, got.red, got.green, got.blue,
                                           got.last));
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[led_strip_animation_generator] ERROR");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_solid_and_spare_modes();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_POWER, 9'd0);
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_SOLID));
        send_tick(1'b1);
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(MODE_SPARE_LO));
        send_tick(1'b1);
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(MODE_SPARE_HI));
        send_tick(1'b1);
    endtask

    task automatic test_length_limits();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_XMAS2));
        write_reg(lsag_pkg::REG_POWER, 9'd256);
        write_reg(lsag_pkg::REG_LENGTH, 9'd0);
        send_tick(1'b1);
        wait_strip_idle();
        write_reg(lsag_pkg::REG_LENGTH, 9'd127);
        send_tick(1'b1);
        wait_strip_idle();
        write_reg(lsag_pkg::REG_LENGTH, 9'd64);
        send_tick(1'b1);
    endtask

    task automatic test_power_limits();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_XMAS));
        write_reg(lsag_pkg::REG_LENGTH, 9'd5);
        foreach (power_steps[k]) begin
            wait_strip_idle();
            write_reg(lsag_pkg::REG_POWER, power_steps[k]);
            send_tick(1'b1);
        end
    endtask

    task automatic test_snake_short_strip();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_SNAKE));
        write_reg(lsag_pkg::REG_LENGTH, 9'd6);
        write_reg(lsag_pkg::REG_POWER, 9'd200);
        write_reg(lsag_pkg::REG_RED, 9'd255);
        write_reg(lsag_pkg::REG_GREEN, 9'd129);
        write_reg(lsag_pkg::REG_BLUE, 9'd126);
        repeat (4) send_tick(1'b1);
        // shrink below the current phase without touching mode
        wait_strip_idle();
        write_reg(lsag_pkg::REG_LENGTH, 9'd3);
        repeat (2) send_tick(1'b1);
    endtask

    task automatic test_pulse_peak();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_PULSE));
        write_reg(lsag_pkg::REG_LENGTH, 9'd2);
        write_reg(lsag_pkg::REG_POWER, 9'd256);
        write_reg(lsag_pkg::REG_GREEN, 9'd255);
        write_reg(lsag_pkg::REG_BLUE, 9'd255);
        repeat (3) send_tick(1'b1);
    endtask

    // Run the ramp through its turn-around and wrap.
    task automatic test_pulse_full_cycle();
        wait_strip_idle();
        write_reg(lsag_pkg::REG_MODE, 9'(lsag_pkg::MODE_PULSE));
        write_reg(lsag_pkg::REG_LENGTH, 9'($urandom_range(1, 3)));
        write_reg(lsag_pkg::REG_POWER, 9'($urandom_range(128, 511)));
        write_reg(lsag_pkg::REG_RED, 9'($urandom_range(0, 255)));
        write_reg(lsag_pkg::REG_GREEN, 9'($urandom_range(0, 255)));
        write_reg(lsag_pkg::REG_BLUE, 9'($urandom_range(0, 255)));
        repeat (RAMP_PERIOD + 4) begin
            if ($urandom_range(19) == 0) send_tick(1'b0);
            send_tick(1'b1);
        end
    endtask

    task automatic test_random_frames(int n_frames);
        int         sent, run;
        logic [8:0] value;
        sent = 0;
        while (sent < n_frames) begin
            wait_strip_idle();
            if ($urandom_range(9) < 4)
                write_reg(lsag_pkg::REG_MODE, 9'($urandom_range(0, 7)));
            if ($urandom_range(1)) begin
                case ($urandom_range(11))
                    0:       value = 9'd0;
                    1:       value = 9'd64;
                    2:       value = 9'd65;
                    3:       value = 9'd127;
                    4:       value = 9'($urandom_range(17, 64));
                    default: value = 9'($urandom_range(1, 16));
                endcase
                write_reg(lsag_pkg::REG_LENGTH, value);
            end
            if ($urandom_range(1)) begin
                case ($urandom_range(5))
                    0:       value = 9'd0;
                    1:       value = 9'd256;
                    2:       value = 9'd511;
                    default: value = 9'($urandom_range(0, 511));
                endcase
                write_reg(lsag_pkg::REG_POWER, value);
            end
            if ($urandom_range(1))
                write_reg(lsag_pkg::REG_RED, 9'($urandom_range(0, 255)));
            if ($urandom_range(1))
                write_reg(lsag_pkg::REG_GREEN, 9'($urandom_range(0, 255)));
            if ($urandom_range(1))
                write_reg(lsag_pkg::REG_BLUE, 9'($urandom_range(0, 255)));
            run = $urandom_range(1, 12);
            repeat (run) begin
                if ($urandom_range(9) == 0) send_tick(1'b0);
                send_tick(1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.frame_tick = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_solid_and_spare_modes();
        test_length_limits();
        test_power_limits();
        test_snake_short_strip();
        test_pulse_peak();

        test_pulse_full_cycle();
        test_random_frames(75);
        src_idle_pct = 51;
        sink_stall_pct = 0;
        test_random_frames(75);
        src_idle_pct = 0;
        sink_stall_pct = 51;
        test_random_frames(75);
        src_idle_pct = 20;
        sink_stall_pct = 20;
        test_random_frames(80);

        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("[led_strip_animation_generator] OK");
        end else begin
            $display("[led_strip_animation_generator] ERROR");
        end
        $finish;
    end

endmodule
